// ===== rtl/ppa_pkg.sv =====
// Shared types, operation codes and bit helpers for the prefix-preserving
// address anonymizer. No dependencies.
package ppa_pkg;

    localparam logic [1:0] OP_RESTART = 2'd0;
    localparam logic [1:0] OP_MAP     = 2'd1;
    localparam logic [1:0] OP_PIN     = 2'd2;

    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [31:0] LOW24_MASK = 32'h00FF_FFFF;
    localparam logic [31:0] TOP8_MASK  = 32'hFF00_0000;

    typedef struct packed {
        logic [5:0]  prefix_bits;
        logic [31:0] root_seed;
    } t_cfg;

    // Isolates the most significant set bit of a word.
    function automatic logic [31:0] msb_mask(input logic [31:0] x);
        logic [31:0] s;
        s = x;
        s = s | (s >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        s = s | (s >> 8);
        s = s | (s >> 16);
        return s & ~(s >> 1);
    endfunction

    // Bit position of a one-hot word.
    function automatic logic [4:0] onehot_index(input logic [31:0] m);
        logic [4:0] idx;
        idx = '0;
        for (int i = 0; i < 32; i++) begin
            if (m[i]) begin
                idx = idx | 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/prefix_preserving_addr_anonymizer.sv =====
// Top level of the prefix-preserving address anonymizer.
// Depends on ppa_pkg, ppa_cfg, ppa_ram and ppa_ctrl.
//
// Each request yields one result. A restart or an unused operation needs no
// trie walk. A map or pin request walks a binary trie held in one node memory
// with a registered read. Every inner trie level reads the node, then the keys
// of its two children, one memory read each. The last node visited is read
// once, and a new leaf adds write-backs of the moved node, the new leaf and
// then the split node. Requests are taken one at a time; the next one is
// accepted as soon as the previous result sits in the output register, even
// if the consumer still stalls it. The node memory needs no clearing: a
// restart request builds the root, and every other entry is written before
// it is first read. Issue a restart before the first map or pin request.
module prefix_preserving_addr_anonymizer #(
    parameter int NODE_COUNT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_address,
    input  logic [30:0] i_random_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_mapped_address,
    output logic        o_status
);
    import ppa_pkg::*;

    localparam int AW = $clog2(NODE_COUNT);
    localparam int NW = 65 + 2 * AW;

    t_cfg          cfg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [NW-1:0] mem_wdata, mem_rdata;

    // Configuration registers, written by the user only while no request is in flight; unchecked by the block.
    ppa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Node memory: key, image, child indices and leaf flag in one word.
    ppa_ram #(
        .WIDTH (NW),
        .DEPTH (NODE_COUNT)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Walk and split sequencer with the output register.
    ppa_ctrl #(
        .NODE_COUNT (NODE_COUNT)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_operation      (i_operation),
        .i_address        (i_address),
        .i_random_bits    (i_random_bits),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_mapped_address (o_mapped_address),
        .o_status         (o_status),
        .o_mem_we         (mem_we),
        .o_mem_waddr      (mem_waddr),
        .o_mem_wdata      (mem_wdata),
        .o_mem_re         (mem_re),
        .o_mem_raddr      (mem_raddr),
        .i_mem_rdata      (mem_rdata)
    );
endmodule

// ===== rtl/ppa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ppa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/ppa_cfg.sv =====
// APB-style register file for the anonymizer: prefix bits and root seed.
// Depends on ppa_pkg.
module ppa_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output ppa_pkg::t_cfg o_cfg
);
    import ppa_pkg::*;

    logic [5:0]  r_prefix_bits;
    logic [31:0] r_root_seed;
    logic        wr;

    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_bits <= '0;
            r_root_seed   <= '0;
        end else if (wr) begin
            if (paddr[2]) begin
                r_root_seed <= pwdata;
            end else begin
                r_prefix_bits <= pwdata[5:0];
            end
        end
    end

    assign prdata = paddr[2] ? r_root_seed : {26'd0, r_prefix_bits};
    assign pready = 1'b1;
    assign o_cfg  = '{prefix_bits: r_prefix_bits, root_seed: r_root_seed};
endmodule

// ===== rtl/ppa_ctrl.sv =====
// Trie walk and split sequencer: reads, modifies and writes back node memory.
// Depends on ppa_pkg; drives the node RAM ports of ppa_ram.
module ppa_ctrl #(
    parameter int NODE_COUNT = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ppa_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_operation,
    input  logic [31:0]                   i_address,
    input  logic [30:0]                   i_random_bits,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [31:0]                   o_mapped_address,
    output logic                          o_status,
    output logic                          o_mem_we,
    output logic [$clog2(NODE_COUNT)-1:0] o_mem_waddr,
    output logic [64+2*$clog2(NODE_COUNT):0] o_mem_wdata,
    output logic                          o_mem_re,
    output logic [$clog2(NODE_COUNT)-1:0] o_mem_raddr,
    input  logic [64+2*$clog2(NODE_COUNT):0] i_mem_rdata
);
    import ppa_pkg::*;

    localparam int AW = $clog2(NODE_COUNT);
    localparam logic [AW+1:0] NODE_LIMIT = (AW+2)'(NODE_COUNT);

    typedef struct packed {
        logic [31:0]   key;
        logic [31:0]   image;
        logic [AW-1:0] left;
        logic [AW-1:0] right;
        logic          leaf;
    } t_node;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b0_0000_0001,
        S_NODE  = 9'b0_0000_0010,
        S_LKEY  = 9'b0_0000_0100,
        S_RKEY  = 9'b0_0000_1000,
        S_SPLIT = 9'b0_0001_0000,
        S_WLEAF = 9'b0_0010_0000,
        S_WNODE = 9'b0_0100_0000,
        S_PIN0  = 9'b0_1000_0000,
        S_DONE  = 9'b1_0000_0000
    } t_state;

    t_state        r_state, n_state;
    logic [1:0]    r_op, n_op;
    logic [31:0]   r_a, n_a;
    logic [30:0]   r_rnd, n_rnd;
    logic [AW-1:0] r_n, n_n;
    t_node         r_node, n_node;
    logic [31:0]   r_lkey, n_lkey;
    logic [5:0]    r_depth, n_depth;
    logic [AW:0]   r_next_free, n_next_free;
    logic          r_touched, n_touched;
    logic [31:0]   r_res, n_res;
    logic          r_res_st, n_res_st;
    logic          r_bit, n_bit;
    logic [31:0]   r_img, n_img;
    logic          r_ovalid, n_ovalid;
    logic [31:0]   r_omapped, n_omapped;
    logic          r_ostatus, n_ostatus;

    t_node         rd, wnode;
    logic [31:0]   x, y, xm, ym, img, pin_img, mask, acc_a;
    logic [4:0]    bpos;
    logic [AW-1:0] d0, d1;
    logic          split_now;

    assign rd = t_node'(i_mem_rdata);

    always_comb begin
        n_state = r_state;   n_op = r_op;       n_a = r_a;
        n_rnd = r_rnd;       n_n = r_n;         n_node = r_node;
        n_lkey = r_lkey;     n_depth = r_depth; n_next_free = r_next_free;
        n_touched = r_touched; n_res = r_res;   n_res_st = r_res_st;
        n_bit = r_bit;       n_img = r_img;     n_ovalid = r_ovalid;
        n_omapped = r_omapped; n_ostatus = r_ostatus;
        o_mem_we = 1'b0; o_mem_waddr = '0; wnode = '0;
        o_mem_re = 1'b0; o_mem_raddr = '0;

        mask  = ~(ALL_ONES >> i_cfg.prefix_bits);
        acc_a = (i_operation == OP_PIN) ? (i_address & TOP8_MASK) : i_address;

        x  = r_a ^ r_node.key;
        y  = r_lkey ^ rd.key;
        ym = msb_mask(y);
        split_now = (y == '0) || ((y < x) && (y < (x ^ y)));

        xm   = msb_mask(x);
        bpos = onehot_index(xm);
        img  = (r_node.image & ~(xm | (xm - 32'd1))) | (~r_node.image & xm)
             | ({1'b0, r_rnd} >> (6'd32 - {1'b0, bpos}));
        pin_img = (r_op == OP_PIN) ? ((r_img & LOW24_MASK) | r_a) : r_img;
        d0 = r_next_free[AW-1:0];
        d1 = d0 + 1'b1;

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op = i_operation;  n_a = acc_a;  n_rnd = i_random_bits;
                    n_res = '0;          n_res_st = 1'b0;
                    n_n = '0;            n_depth = '0;
                    n_state = S_DONE;
                    case (i_operation)
                        OP_RESTART: begin
                            o_mem_we    = 1'b1;
                            wnode.key   = (i_cfg.prefix_bits != '0) ? mask : 32'd1;
                            wnode.image = i_cfg.root_seed | mask;
                            wnode.leaf  = 1'b1;
                            n_next_free = (AW+1)'(1);
                            n_touched   = (i_cfg.prefix_bits != '0);
                        end
                        OP_MAP, OP_PIN: begin
                            o_mem_re = 1'b1;
                            n_state  = (i_operation == OP_PIN && !r_touched) ? S_PIN0
                                                                             : S_NODE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_PIN0: begin
                o_mem_we    = 1'b1;
                wnode       = rd;
                wnode.key   = r_a;
                wnode.image = (rd.image & LOW24_MASK) | r_a;
                n_touched   = 1'b1;
                n_res       = wnode.image;
                n_state     = S_DONE;
            end
            S_NODE: begin
                n_node = rd;
                if (rd.key == r_a) begin
                    if (r_op == OP_PIN) begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = r_n;
                        wnode       = rd;
                        wnode.image = (rd.image & LOW24_MASK) | r_a;
                        n_res       = wnode.image;
                    end else begin
                        n_res = rd.image;
                    end
                    n_state = S_DONE;
                end else if (rd.leaf) begin
                    n_state = S_SPLIT;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = rd.left;
                    n_state     = S_LKEY;
                end
            end
            S_LKEY: begin
                n_lkey      = rd.key;
                o_mem_re    = 1'b1;
                o_mem_raddr = r_node.right;
                n_state     = S_RKEY;
            end
            S_RKEY: begin
                if (split_now) begin
                    n_state = S_SPLIT;
                end else if (r_depth == 6'd63) begin
                    n_res_st = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    n_n         = ((r_a & ym) != '0) ? r_node.right : r_node.left;
                    o_mem_re    = 1'b1;
                    o_mem_raddr = n_n;
                    n_depth     = r_depth + 6'd1;
                    n_state     = S_NODE;
                end
            end
            S_SPLIT: begin
                if (r_a == '0 || r_a == ALL_ONES) begin
                    n_res   = r_a;
                    n_state = S_DONE;
                end else if (({1'b0, r_next_free} + (AW+2)'(2)) > NODE_LIMIT) begin
                    n_res_st = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    n_bit       = |(r_a & xm);
                    n_img       = img;
                    o_mem_we    = 1'b1;
                    o_mem_waddr = n_bit ? d0 : d1;
                    wnode       = r_node;
                    n_state     = S_WLEAF;
                end
            end
            S_WLEAF: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_bit ? d1 : d0;
                wnode.key   = r_a;
                wnode.image = pin_img;
                wnode.leaf  = 1'b1;
                n_res       = pin_img;
                n_state     = S_WNODE;
            end
            S_WNODE: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_n;
                wnode.key   = r_bit ? r_a : r_node.key;
                wnode.image = r_bit ? r_img : r_node.image;
                wnode.left  = d0;
                wnode.right = d1;
                wnode.leaf  = 1'b0;
                n_next_free = r_next_free + (AW+1)'(2);
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid  = 1'b1;
                    n_omapped = r_res;
                    n_ostatus = r_res_st;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_mem_wdata = wnode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_free <= (AW+1)'(1);
            r_touched   <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_free <= n_next_free;
            r_touched   <= n_touched;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;       r_a <= n_a;         r_rnd <= n_rnd;
        r_n <= n_n;         r_node <= n_node;   r_lkey <= n_lkey;
        r_depth <= n_depth; r_res <= n_res;     r_res_st <= n_res_st;
        r_bit <= n_bit;     r_img <= n_img;
        r_omapped <= n_omapped; r_ostatus <= n_ostatus;
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_mapped_address = r_omapped;
    assign o_status         = r_ostatus;
endmodule

// ===== test/ppa_checker.sv =====
// Checker for the prefix-preserving address anonymizer: tracks register writes,
// predicts every result from its own trie copy and compares. Depends on ppa_pkg.
`timescale 1ns / 100ps

package ppa_tb_pkg;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] REG_PREFIX_BITS = 3'd0;
    localparam logic [2:0] REG_ROOT_SEED   = 3'd4;
endpackage

module ppa_checker #(
    parameter int NODE_COUNT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_address,
    input  logic [30:0] i_random_bits,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [31:0] o_mapped_address,
    input  logic        o_status,
    output int          o_fail_count,
    output int          o_pending
);
    import ppa_pkg::*;
    import ppa_tb_pkg::*;

    typedef struct packed {
        logic [31:0] mapped;
        logic        status;
    } t_anon_result;

    logic [5:0]  cfg_prefix_bits;
    logic [31:0] cfg_root_seed;

    logic [31:0] trie_key   [NODE_COUNT];
    logic [31:0] trie_image [NODE_COUNT];
    int          trie_left  [NODE_COUNT];
    int          trie_right [NODE_COUNT];
    logic        trie_leaf  [NODE_COUNT];
    int          trie_next_free;
    logic        root_pinned;

    t_anon_result expected_results[$];

    assign o_pending = expected_results.size();

    // 1-based position of the leading one, counted from bit 31; 0 for zero.
    function automatic int leading_one(input logic [31:0] x);
        for (int i = 31; i >= 0; i--) begin
            if (x[i]) return 32 - i;
        end
        return 0;
    endfunction

    // Splits node n so that a gets a leaf of its own. Returns 1 when out of
    // nodes. leaf is NODE_COUNT for the two self-mapped addresses.
    function automatic logic split_node(input logic [31:0] a, input int n,
                                        input logic [30:0] rnd, output int leaf);
        int          d0, d1, s, bit_pos;
        logic        b;
        logic [31:0] img, old;
        if (a == 32'd0 || a == ALL_ONES) begin
            leaf = NODE_COUNT;
            return 1'b0;
        end
        if (trie_next_free + 2 > NODE_COUNT) return 1'b1;
        d0 = trie_next_free;
        d1 = trie_next_free + 1;
        trie_next_free += 2;
        s = leading_one(a ^ trie_key[n]);
        bit_pos = 32 - s;
        b = a[bit_pos];
        old = trie_image[n];
        if (s == 32)
            img = old ^ 32'd1;
        else
            img = (((old >> bit_pos) ^ 32'd1) << bit_pos) | ({1'b0, rnd} >> s);
        // The old contents move to the peer on the other side of the split.
        if (b) begin
            trie_key[d0] = trie_key[n];   trie_image[d0] = trie_image[n];
            trie_left[d0] = trie_left[n]; trie_right[d0] = trie_right[n];
            trie_leaf[d0] = trie_leaf[n];
            leaf = d1;
        end else begin
            trie_key[d1] = trie_key[n];   trie_image[d1] = trie_image[n];
            trie_left[d1] = trie_left[n]; trie_right[d1] = trie_right[n];
            trie_leaf[d1] = trie_leaf[n];
            leaf = d0;
        end
        trie_key[leaf] = a;
        trie_image[leaf] = img;
        trie_left[leaf] = 0;
        trie_right[leaf] = 0;
        trie_leaf[leaf] = 1'b1;
        trie_key[n] = trie_key[d1];
        trie_image[n] = trie_image[d1];
        trie_left[n] = d0;
        trie_right[n] = d1;
        trie_leaf[n] = 1'b0;
        return 1'b0;
    endfunction

    // Finds or inserts a; returns 1 on failure.
    function automatic logic find_or_insert(input logic [31:0] a, input logic [30:0] rnd,
                                            output int leaf);
        int   n, l, r, sw;
        logic do_split;
        n = 0;
        leaf = NODE_COUNT;
        for (int depth = 0; depth < 64; depth++) begin
            do_split = trie_leaf[n];
            if (trie_key[n] == a) begin
                leaf = n;
                return 1'b0;
            end
            if (!do_split) begin
                l = trie_left[n];
                r = trie_right[n];
                if (l >= NODE_COUNT || r >= NODE_COUNT) begin
                    do_split = 1'b1;
                end else begin
                    sw = leading_one(trie_key[l] ^ trie_key[r]);
                    if (sw == 0 || leading_one(a ^ trie_key[n]) < sw)
                        do_split = 1'b1;
                    else
                        n = a[32 - sw] ? r : l;
                end
            end
            if (do_split) return split_node(a, n, rnd, leaf);
        end
        return 1'b1;
    endfunction

    function automatic t_anon_result anonymize(input logic [1:0] op, input logic [31:0] addr,
                                               input logic [30:0] rnd);
        t_anon_result res;
        int           p, leaf;
        logic [31:0]  mask, a;
        res = '0;
        case (op)
            OP_RESTART: begin
                p = (cfg_prefix_bits > 32) ? 32 : int'(cfg_prefix_bits);
                trie_next_free = 1;
                trie_key[0] = 32'd1;
                trie_image[0] = cfg_root_seed;
                trie_left[0] = 0;
                trie_right[0] = 0;
                trie_leaf[0] = 1'b1;
                root_pinned = 1'b0;
                if (p > 0) begin
                    mask = (p >= 32) ? ALL_ONES : ~(ALL_ONES >> p);
                    trie_key[0] = mask;
                    trie_image[0] |= mask;
                    root_pinned = 1'b1;
                end
            end
            OP_MAP: begin
                if (find_or_insert(addr, rnd, leaf))
                    res.status = 1'b1;
                else
                    res.mapped = (leaf == NODE_COUNT) ? addr : trie_image[leaf];
            end
            OP_PIN: begin
                a = addr & TOP8_MASK;
                if (!root_pinned) begin
                    trie_key[0] = a;
                    trie_image[0] = (trie_image[0] & LOW24_MASK) | a;
                    root_pinned = 1'b1;
                    res.mapped = trie_image[0];
                end else if (find_or_insert(a, rnd, leaf)) begin
                    res.status = 1'b1;
                end else if (leaf == NODE_COUNT) begin
                    res.mapped = a;
                end else begin
                    trie_image[leaf] = (trie_image[leaf] & LOW24_MASK) | a;
                    res.mapped = trie_image[leaf];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_anon_result want;
        if (!i_rst_n) begin
            cfg_prefix_bits <= '0;
            cfg_root_seed <= '0;
            trie_next_free = 1;
            root_pinned = 1'b0;
            expected_results.delete();
            o_fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == REG_PREFIX_BITS) cfg_prefix_bits <= pwdata[5:0];
                else if (paddr == REG_ROOT_SEED) cfg_root_seed <= pwdata;
            end
            // Results are compared before the new request is predicted: a
            // result can never leave on the edge its own request enters.
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: unexpected result mapped=%h status=%0d",
                                 o_mapped_address, o_status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.mapped !== o_mapped_address || want.status !== o_status) begin
                        if (o_fail_count < 10)
                            $display("ERROR: mapped exp %h got %h, status exp %0d got %0d",
                                     want.mapped, o_mapped_address, want.status, o_status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_valid && !o_stall)
                expected_results = {expected_results,
                                    anonymize(i_operation, i_address, i_random_bits)};
        end
    end

endmodule

// ===== test/prefix_preserving_addr_anonymizer_tb.sv =====
// Testbench top for the prefix-preserving address anonymizer: makes requests,
// register writes and stalls. Depends on ppa_pkg, ppa_tb_pkg, ppa_checker and the RTL.
`timescale 1ns / 100ps

module prefix_preserving_addr_anonymizer_tb;
    import ppa_pkg::*;
    import ppa_tb_pkg::*;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_operation = OP_RESTART;
    logic [31:0] i_address = '0;
    logic [30:0] i_random_bits = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_mapped_address;
    logic        o_status;

    int mismatch_count;
    int requests_in_flight;

    // Shared knobs between the request side and the result side.
    bit no_idle = 1'b0;       // both sides run back to back while set
    bit long_hold_req = 1'b0; // result side holds off for a long stretch once

    // Small pool of address prefixes so that random requests share long
    // prefixes and the trie grows deep instead of wide.
    logic [31:0] prefix_pool[8];
    logic [31:0] seen_addrs[$];

    prefix_preserving_addr_anonymizer dut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .i_valid, .o_stall, .i_operation, .i_address, .i_random_bits,
        .o_valid, .i_stall, .o_mapped_address, .o_status
    );

    ppa_checker u_checker (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .i_valid, .o_stall, .i_operation, .i_address, .i_random_bits,
        .o_valid, .i_stall, .o_mapped_address, .o_status,
        .o_fail_count(mismatch_count), .o_pending(requests_in_flight)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #40ms;
        $display("Verification failed");
        $finish;
    end

    // Result side: a random stall before each result, plus one long hold that
    // lets the block fill up and push back on the request side.
    initial begin
        int n;
        forever begin
            if (long_hold_req) begin
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                n = no_idle ? 0 : $urandom_range(0, 5);
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Two-phase register write; the write lands on the access edge.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Drops valid and waits until every outstanding request has produced its
    // result. The first edge lets the checker count the last accepted request.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (requests_in_flight != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [5:0] prefix_bits, input logic [31:0] seed);
        drain();
        write_reg(REG_PREFIX_BITS, {26'd0, prefix_bits});
        write_reg(REG_ROOT_SEED, seed);
    endtask

    // Offers one request and returns once it has been taken. A request that
    // follows with no gap keeps valid high, so valid is never toggled in a step.
    task automatic send_request(input logic [1:0] op, input logic [31:0] addr,
                                input logic [30:0] rnd);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_address <= addr;
        i_random_bits <= rnd;
        do @(posedge i_clk); while (o_stall);
        if (op == OP_MAP) seen_addrs = {seen_addrs, addr};
    endtask

    task automatic map_addr(input logic [31:0] addr);
        send_request(OP_MAP, addr, 31'($urandom));
    endtask

    function automatic logic [31:0] pick_address();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55)
            return prefix_pool[$urandom_range(0, 7)] ^ ($urandom >> $urandom_range(4, 31));
        else if (k < 75 && seen_addrs.size() > 0)
            return seen_addrs[$urandom_range(0, seen_addrs.size() - 1)];
        else if (k < 80)
            return $urandom_range(0, 1) ? 32'd0 : ALL_ONES;
        return $urandom;
    endfunction

    // One random stretch: a mix dominated by map requests on related
    // addresses, with pins, the odd restart and unused operation codes.
    task automatic random_phase(input int count);
        int k;
        send_request(OP_RESTART, $urandom, 31'($urandom));
        seen_addrs.delete();
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 99);
            if (k < 78)
                map_addr(pick_address());
            else if (k < 90)
                send_request(OP_PIN, pick_address(), 31'($urandom));
            else if (k < 93)
                send_request(OP_RESTART, $urandom, 31'($urandom));
            else if (k < 96)
                send_request(OP_UNUSED, $urandom, 31'($urandom));
            else
                map_addr(seen_addrs.size() > 0 ? seen_addrs[0] ^ 32'd1 : $urandom);
        end
    endtask

    initial begin
        int prefix_choice;
        foreach (prefix_pool[i]) prefix_pool[i] = $urandom;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. The block must see a restart before any map or pin.
        set_config(6'd0, 32'h0000_0000);
        send_request(OP_RESTART, 32'd0, 31'd0);
        map_addr(32'h0000_0000);                         // self-mapped low end
        map_addr(ALL_ONES);                              // self-mapped high end
        send_request(OP_PIN, 32'h0A12_3456, 31'h7FFF_FFFF); // pins the fresh root
        map_addr(32'h0A00_0001);
        map_addr(32'h0A00_0000);                         // differs only in bit 0
        map_addr(32'h8000_0000);
        map_addr(32'h0A00_0001);                         // already in the trie
        send_request(OP_PIN, 32'hC0A8_0101, 31'd0);      // pin through a walk
        send_request(OP_PIN, 32'h00FF_FFFF, 31'd0);      // pin of the zero /8
        send_request(OP_UNUSED, ALL_ONES, 31'h7FFF_FFFF);
        send_request(OP_RESTART, 32'd0, 31'd0);
        send_request(OP_PIN, 32'h0000_0000, 31'd0);      // root takes key zero
        map_addr(32'h0000_0000);                         // finds the root first
        map_addr(32'h7FFF_FFFF);

        set_config(6'd32, ALL_ONES);                     // all-ones mask
        send_request(OP_RESTART, 32'd0, 31'd0);
        map_addr(32'h1234_5678);
        send_request(OP_PIN, 32'hFF00_0000, 31'd0);
        set_config(6'd63, 32'h5A5A_A5A5);                // saturates to 32
        send_request(OP_RESTART, 32'd0, 31'd0);
        map_addr(32'hFFFF_FFFE);
        set_config(6'd8, 32'h1357_9BDF);
        send_request(OP_RESTART, 32'd0, 31'd0);
        send_request(OP_PIN, 32'h2200_0000, 31'd0);      // root already touched
        map_addr(32'h22FF_0000);

        // Random part over several register settings, extremes included.
        for (int phase = 0; phase < 6; phase++) begin
            prefix_choice = $urandom_range(0, 5);
            case (prefix_choice)
                0: set_config(6'd0, $urandom);
                1: set_config(6'd32, $urandom);
                2: set_config(6'd63, 32'd0);
                default: set_config(6'($urandom_range(1, 31)), $urandom);
            endcase
            if (phase == 2) begin
                long_hold_req = 1'b1;
            end
            if (phase == 4) begin
                no_idle = 1'b1;
            end
            random_phase(200);
            no_idle = 1'b0;
        end

        // A back-to-back stretch of fresh addresses, then a short random tail.
        set_config(6'd0, $urandom);
        no_idle = 1'b1;
        send_request(OP_RESTART, 32'd0, 31'd0);
        for (int i = 0; i < 150; i++)
            map_addr($urandom | 32'h0000_0100);
        send_request(OP_PIN, 32'h7700_0000, 31'($urandom));
        map_addr(32'h0000_0000);
        no_idle = 1'b0;
        drain();
        random_phase(40);

        drain();
        repeat (150) @(posedge i_clk);
        if (mismatch_count == 0 && requests_in_flight == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
